>>> src/bspm_pkg.sv
// shared constants, codes and the queue entry type of the pixel mixer
package bspm_pkg;

  // line store geometry, LINE_WIDTH must be a multiple of four
  localparam int LINE_WIDTH    = 512;
  localparam int LS_IW         = $clog2(LINE_WIDTH);
  localparam int LS_ROWS       = LINE_WIDTH / 2;
  localparam int LS_RW         = LS_IW - 1;
  localparam int LS_BANK_DEPTH = LS_ROWS / 2;
  localparam int LS_BW         = LS_RW - 1;

  // smoothing table geometry
  localparam int TABLE_BANKS = 4;
  localparam int TBL_DEPTH   = TABLE_BANKS * 256;
  localparam int TBL_AW      = $clog2(TBL_DEPTH);

  // front to back queue
  localparam int QUEUE_DEPTH = 4;

  // configuration port
  localparam int CFG_IW = 1;
  localparam int CFG_DW = 9;
  localparam logic [CFG_IW-1:0] CFG_HSCROLL = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] CFG_BANK    = CFG_IW'(1);

  // input function codes
  localparam logic [1:0] FUNC_PIXEL    = 2'd0;
  localparam logic [1:0] FUNC_LOAD_ONE = 2'd1;
  localparam logic [1:0] FUNC_LOAD_TWO = 2'd2;

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_LOAD_ONE,
    KIND_LOAD_TWO
  } kind_e;

  // one classified beat waiting for the back end
  typedef struct packed {
    kind_e                 kind;
    logic [1:0]            text_first;
    logic [1:0]            text_second;
    logic [3:0]            raw;
    logic [3:0]            prev;
    logic                  frame_start;
    logic                  odd;
    logic                  lead_bank;
    logic [1:0][LS_RW-1:0] bank_row;
    logic [TBL_AW-1:0]     tindex;
    logic [3:0]            tvalue;
  } entry_t;

endpackage

>>> src/bspm_front.sv
// front end: accepts beats, picks colours and text bits, tracks the previous colour
module bspm_front import bspm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        full_i,
  input  logic [1:0]  func_i,
  input  logic [8:0]  column_i,
  input  logic        first_in_line_i,
  input  logic        first_in_frame_i,
  input  logic [7:0]  text_byte_i,
  input  logic [7:0]  background_plane_a_i,
  input  logic [7:0]  background_plane_b_i,
  input  logic        background_flip_i,
  input  logic [9:0]  table_index_i,
  input  logic [3:0]  table_value_i,
  input  logic [8:0]  hscroll_i,
  output logic        push_o,
  output entry_t      entry_o
);

  logic             accept;
  logic             keep;
  logic             in_range;
  kind_e            kind;
  logic [8:0]       scrolled;
  logic [1:0]       slot;
  logic [2:0]       hi_sel;
  logic [2:0]       lo_sel;
  logic [3:0]       raw;
  logic [10:0]      col_w;
  logic [LS_IW-1:0] ent0;
  logic [LS_RW-1:0] row0;
  logic [LS_RW-1:0] row1;
  logic [3:0]       prev_q;

  assign accept   = in_valid_i && !full_i;
  assign in_range = {1'b0, table_index_i} < 11'(TBL_DEPTH);

  // scrolled column and background colour pick
  always_comb begin
    scrolled = column_i + hscroll_i;
    if (background_flip_i) begin
      scrolled = scrolled ^ 9'h00f;
    end
    slot   = scrolled[2:1];
    hi_sel = 3'd7 - {1'b0, slot};
    lo_sel = 3'd3 - {1'b0, slot};
    raw    = {background_plane_a_i[hi_sel], background_plane_a_i[lo_sel],
              background_plane_b_i[hi_sel], background_plane_b_i[lo_sel]};
  end

  // line store entry and the two rows the pair touches
  always_comb begin
    col_w = 11'(column_i);
    if (col_w >= 11'(LINE_WIDTH)) begin
      col_w = col_w - 11'(LINE_WIDTH);
    end
    ent0 = col_w[LS_IW-1:0];
    row0 = ent0[LS_IW-1:1];
    row1 = (row0 == LS_RW'(LS_ROWS - 1)) ? '0 : row0 + LS_RW'(1);
  end

  // classify the beat
  always_comb begin
    unique case (func_i)
      FUNC_PIXEL: begin
        keep = 1'b1;
        kind = KIND_PIXEL;
      end
      FUNC_LOAD_ONE: begin
        keep = in_range;
        kind = KIND_LOAD_ONE;
      end
      FUNC_LOAD_TWO: begin
        keep = in_range;
        kind = KIND_LOAD_TWO;
      end
      default: begin
        keep = 1'b0;
        kind = KIND_PIXEL;
      end
    endcase
  end

  assign push_o = accept && keep;

  // queue entry
  always_comb begin
    entry_o.kind        = kind;
    entry_o.text_first  = column_i[1] ? text_byte_i[3:2] : text_byte_i[7:6];
    entry_o.text_second = column_i[1] ? text_byte_i[1:0] : text_byte_i[5:4];
    entry_o.raw         = raw;
    entry_o.prev        = first_in_line_i ? 4'h0 : prev_q;
    entry_o.frame_start = first_in_frame_i;
    entry_o.odd         = ent0[0];
    entry_o.lead_bank   = row0[0];
    entry_o.bank_row    = row0[0] ? {row0, row1} : {row1, row0};
    entry_o.tindex      = table_index_i[TBL_AW-1:0];
    entry_o.tvalue      = table_value_i;
  end

  // previous pair colour
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 4'h0;
    end else if (accept && (func_i == FUNC_PIXEL)) begin
      prev_q <= raw;
    end
  end

endmodule

>>> src/bspm_queue.sv
// short fifo between front and back end
module bspm_queue import bspm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_entry_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   head_valid_o,
  output entry_t head_o
);

  localparam int QP_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           slot_q [QUEUE_DEPTH];
  logic [QP_W-1:0]  wr_ptr_q;
  logic [QP_W-1:0]  rd_ptr_q;
  logic [QC_W-1:0]  count_q;

  assign full_o       = (count_q == QC_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slot_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QP_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QP_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QC_W'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - QC_W'(1);
      end
    end
  end

endmodule

>>> src/bspm_back.sv
// back end: smoothing tables, line store and the output register
module bspm_back import bspm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  entry_t     head_i,
  input  logic [1:0] bank_i,
  output logic       pop_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output logic [9:0] pen_first_o,
  output logic [9:0] pen_second_o
);

  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [1:0] bank,
                                                 input logic [3:0] hi,
                                                 input logic [3:0] lo);
    return TBL_AW'({bank, hi, lo});
  endfunction

  logic              adv;
  logic              head_pixel;
  logic [3:0]        t1_mem [TBL_DEPTH];
  logic [3:0]        t2_mem [TBL_DEPTH];
  logic [3:0]        t1_rd_q;
  logic [3:0]        t2a_q;
  logic [3:0]        t2b_q;
  logic              s2_valid_q;
  logic              s3_valid_q;
  entry_t            s2_q;
  logic [1:0]        s3_text_first_q;
  logic [1:0]        s3_text_second_q;
  logic [7:0]        word [2];
  logic [1:0][7:0]   wr_word;
  logic [1:0]        wr_en;
  logic [LS_ROWS-1:0] row_valid_q;
  logic [3:0]        smooth;
  logic [3:0]        ls0;
  logic [3:0]        ls1;
  logic [7:0]        lead_w;
  logic [7:0]        trail_w;
  logic [7:0]        lead_word;
  logic [7:0]        trail_word;
  logic              trail_en;
  logic [TBL_AW-1:0] t1_addr;
  logic [TBL_AW-1:0] t2a_addr;
  logic [TBL_AW-1:0] t2b_addr;

  assign adv        = !s3_valid_q || !out_stall_i;
  assign pop_o      = adv && head_valid_i;
  assign head_pixel = head_valid_i && (head_i.kind == KIND_PIXEL);
  assign t1_addr    = tbl_addr(bank_i, head_i.prev, head_i.raw);

  // smoothing table one, loaded and read from the queue head
  always_ff @(posedge clk_i) begin
    if (pop_o && (head_i.kind == KIND_LOAD_ONE)) begin
      t1_mem[head_i.tindex] <= head_i.tvalue;
    end
    if (adv) begin
      t1_rd_q <= t1_mem[t1_addr];
    end
  end

  // line store rows of the pair, merged with the new colours
  always_comb begin
    smooth  = t1_rd_q;
    lead_w  = word[s2_q.lead_bank];
    trail_w = word[~s2_q.lead_bank];
    if (s2_q.odd) begin
      ls0        = lead_w[7:4];
      ls1        = trail_w[3:0];
      lead_word  = {smooth, lead_w[3:0]};
      trail_word = {trail_w[7:4], s2_q.raw};
      trail_en   = s2_valid_q;
    end else begin
      ls0        = lead_w[3:0];
      ls1        = lead_w[7:4];
      lead_word  = {s2_q.raw, smooth};
      trail_word = trail_w;
      trail_en   = 1'b0;
    end
    wr_word  = s2_q.lead_bank ? {lead_word, trail_word} : {trail_word, lead_word};
    wr_en    = s2_q.lead_bank ? {s2_valid_q, trail_en} : {trail_en, s2_valid_q};
    t2a_addr = tbl_addr(bank_i, ls0, smooth);
    t2b_addr = tbl_addr(bank_i, ls1, s2_q.raw);
  end

  // line store banks by row parity, with write forwarding to the next pair
  for (genvar b = 0; b < 2; b++) begin : g_bank
    logic [7:0]       mem [LS_BANK_DEPTH];
    logic [LS_RW-1:0] rd_row;
    logic [LS_RW-1:0] wr_row;
    logic [7:0]       rd_q;
    logic [7:0]       fwd_word_q;
    logic             fwd_q;
    logic             vld_q;

    assign rd_row  = head_i.bank_row[b];
    assign wr_row  = s2_q.bank_row[b];
    assign word[b] = fwd_q ? fwd_word_q : (vld_q ? rd_q : 8'h00);

    always_ff @(posedge clk_i) begin
      if (adv && wr_en[b]) begin
        mem[wr_row[LS_RW-1:1]] <= wr_word[b];
      end
      if (adv) begin
        rd_q       <= mem[rd_row[LS_RW-1:1]];
        fwd_q      <= wr_en[b] && (wr_row == rd_row) && !head_i.frame_start;
        fwd_word_q <= wr_word[b];
        vld_q      <= row_valid_q[rd_row] && !head_i.frame_start;
      end
    end
  end

  // smoothing table two, two reads per pair
  always_ff @(posedge clk_i) begin
    if (pop_o && (head_i.kind == KIND_LOAD_TWO)) begin
      t2_mem[head_i.tindex] <= head_i.tvalue;
    end
    if (adv) begin
      t2a_q <= t2_mem[t2a_addr];
      t2b_q <= t2_mem[t2b_addr];
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q             <= head_i;
      s3_text_first_q  <= s2_q.text_first;
      s3_text_second_q <= s2_q.text_second;
    end
  end

  // stage valids and line store row valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      row_valid_q <= '0;
    end else if (adv) begin
      s2_valid_q <= head_pixel;
      s3_valid_q <= s2_valid_q;
      if (head_pixel && head_i.frame_start) begin
        row_valid_q <= '0;
      end else begin
        if (wr_en[0]) begin
          row_valid_q[s2_q.bank_row[0]] <= 1'b1;
        end
        if (wr_en[1]) begin
          row_valid_q[s2_q.bank_row[1]] <= 1'b1;
        end
      end
    end
  end

  assign out_valid_o  = s3_valid_q;
  assign pen_first_o  = {s3_text_first_q, 4'b0000, t2a_q};
  assign pen_second_o = {s3_text_second_q, 4'b0000, t2b_q};

endmodule

>>> src/background_smoothing_pixel_mixer.sv
// top level of the background smoothing pixel mixer
// path: an accepted pixel pair beat goes through the queue, the table one and line
//   store read stage, and the table two read stage that forms the output register
// throughput: one beat per cycle unless the output stalls, set by those stages
// reset: control, scroll, bank and line store row valid bits clear at once, so the
//   line store reads zero with no clearing pass; smoothing tables are not cleared
module background_smoothing_pixel_mixer import bspm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        func_i,
  input  logic [8:0]        column_i,
  input  logic              first_in_line_i,
  input  logic              first_in_frame_i,
  input  logic [7:0]        text_byte_i,
  input  logic [7:0]        background_plane_a_i,
  input  logic [7:0]        background_plane_b_i,
  input  logic              background_flip_i,
  input  logic [9:0]        table_index_i,
  input  logic [3:0]        table_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [9:0]        pen_first_o,
  output logic [9:0]        pen_second_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  // bank number folded into the banks that exist
  function automatic logic [1:0] bank_wrap(input logic [1:0] v);
    logic [2:0] r;
    r = {1'b0, v};
    for (int k = 0; k < 4; k++) begin
      if (r >= 3'(TABLE_BANKS)) begin
        r = r - 3'(TABLE_BANKS);
      end
    end
    return r[1:0];
  endfunction

  logic [8:0] hscroll_q;
  logic [1:0] bank_q;
  logic       q_full;
  logic       push;
  entry_t     push_entry;
  logic       pop;
  logic       head_valid;
  entry_t     head;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hscroll_q <= 9'd0;
      bank_q    <= 2'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HSCROLL: hscroll_q <= cfg_data_i[8:0];
        CFG_BANK:    bank_q    <= bank_wrap(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  assign in_stall_o = q_full;

  bspm_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .full_i               (q_full),
    .func_i               (func_i),
    .column_i             (column_i),
    .first_in_line_i      (first_in_line_i),
    .first_in_frame_i     (first_in_frame_i),
    .text_byte_i          (text_byte_i),
    .background_plane_a_i (background_plane_a_i),
    .background_plane_b_i (background_plane_b_i),
    .background_flip_i    (background_flip_i),
    .table_index_i        (table_index_i),
    .table_value_i        (table_value_i),
    .hscroll_i            (hscroll_q),
    .push_o               (push),
    .entry_o              (push_entry)
  );

  bspm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  bspm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .bank_i       (bank_q),
    .pop_o        (pop),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .pen_first_o  (pen_first_o),
    .pen_second_o (pen_second_o)
  );

endmodule

>>> src/bspm_checker.sv
// port level checks of the pixel mixer and their bind
module bspm_checker import bspm_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] func_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [9:0] pen_first_o,
  input logic [9:0] pen_second_o
);

  logic       pix_in;
  logic       pix_out;
  logic [3:0] pend_d;
  logic [3:0] pend_q;

  // pixel pairs taken and not yet handed out
  assign pix_in  = in_valid_i && !in_stall_o && (func_i == FUNC_PIXEL);
  assign pix_out = out_valid_o && !out_stall_i;
  assign pend_d  = pend_q + {3'b000, pix_in} - {3'b000, pix_out};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 4'h0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // a stalled result beat stays and holds its pens
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pen_first_o) &&
                                   $stable(pen_second_o))
    else $error("stalled result beat changed");

  // the input side only stalls behind a stalled result
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled with the output free");

  // pens never carry bits between the text and background fields
  a_pen_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pen_first_o[7:4] == 4'h0) && (pen_second_o[7:4] == 4'h0))
    else $error("pen middle bits set");

  // a result beat always has a pixel pair behind it
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pend_q != 4'h0))
    else $error("result beat without a pixel pair");

endmodule

bind background_smoothing_pixel_mixer bspm_checker u_checker (.*);

>>> tb/sv/background_smoothing_pixel_mixer_test.sv
// self-checking testbench of the background smoothing pixel mixer
module background_smoothing_pixel_mixer_test;
  import bspm_pkg::*;

  // func value with no meaning, the block drops such beats
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // table bank that is fully loaded and used by every pixel pair
  localparam logic [1:0] FILL_BANK   = 2'd2;
  localparam int MAX_WAIT     = 11;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BEATS  = 155;

  typedef struct packed {
    logic [1:0] func;
    logic [8:0] column;
    logic       line_start;
    logic       frame_start;
    logic [7:0] text;
    logic [7:0] plane_a;
    logic [7:0] plane_b;
    logic       flip;
    logic [9:0] tindex;
    logic [3:0] tvalue;
  } beat_t;

  typedef struct packed {
    logic [9:0] first;
    logic [9:0] second;
  } pens_t;

  logic              clk_i                = 1'b0;
  logic              rst_ni               = 1'b0;
  logic              in_valid_i           = 1'b0;
  logic              in_stall_o;
  logic [1:0]        func_i               = '0;
  logic [8:0]        column_i             = '0;
  logic              first_in_line_i      = 1'b0;
  logic              first_in_frame_i     = 1'b0;
  logic [7:0]        text_byte_i          = '0;
  logic [7:0]        background_plane_a_i = '0;
  logic [7:0]        background_plane_b_i = '0;
  logic              background_flip_i    = 1'b0;
  logic [9:0]        table_index_i        = '0;
  logic [3:0]        table_value_i        = '0;
  logic              out_valid_o;
  logic              out_stall_i          = 1'b0;
  logic [9:0]        pen_first_o;
  logic [9:0]        pen_second_o;
  logic              cfg_we_i             = 1'b0;
  logic [CFG_IW-1:0] cfg_index_i          = '0;
  logic [CFG_DW-1:0] cfg_data_i           = '0;

  background_smoothing_pixel_mixer dut (.*);

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [3:0] smooth_one_mem [TBL_DEPTH];
  logic [3:0] smooth_two_mem [TBL_DEPTH];
  logic [3:0] row_above_mem [LINE_WIDTH];
  logic [3:0] prev_colour = '0;
  logic [8:0] scroll      = '0;
  logic [1:0] bank        = '0;

  beat_t beats_waiting[$];
  pens_t pens_due[$];

  int mismatches   = 0;
  int pairs_sent   = 0;
  int loads_sent   = 0;
  int ignored_sent = 0;
  int pens_checked = 0;
  int reg_writes   = 0;

  task automatic report(string what);
    mismatches++;
    $display("mismatch %0d at %0t: %s", mismatches, $time, what);
  endtask

  // wait length for one beat, with stretches of back to back beats
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // expected pens of one accepted beat, table loads update the tables
  task automatic predict_pens(beat_t b);
    logic [8:0] scrolled;
    logic [1:0] slot;
    logic [1:0] text_a;
    logic [1:0] text_b;
    logic [3:0] raw;
    logic [3:0] smooth;
    logic [8:0] i0;
    logic [8:0] i1;
    pens_t      p;
    case (b.func)
      FUNC_LOAD_ONE: begin
        smooth_one_mem[b.tindex] = b.tvalue;
        loads_sent++;
      end
      FUNC_LOAD_TWO: begin
        smooth_two_mem[b.tindex] = b.tvalue;
        loads_sent++;
      end
      FUNC_PIXEL: begin
        if (b.frame_start) begin
          for (int k = 0; k < LINE_WIDTH; k++) row_above_mem[k] = '0;
        end
        if (b.line_start) prev_colour = '0;
        scrolled = b.column + scroll;
        if (b.flip) scrolled = scrolled ^ 9'h00f;
        slot = scrolled[2:1];
        raw = {b.plane_a[7 - slot], b.plane_a[3 - slot],
               b.plane_b[7 - slot], b.plane_b[3 - slot]};
        text_a = b.column[1] ? b.text[3:2] : b.text[7:6];
        text_b = b.column[1] ? b.text[1:0] : b.text[5:4];
        smooth = smooth_one_mem[{bank, prev_colour, raw}];
        i0 = b.column;
        i1 = b.column + 1'b1;
        p.first  = {text_a, 4'h0, smooth_two_mem[{bank, row_above_mem[i0], smooth}]};
        p.second = {text_b, 4'h0, smooth_two_mem[{bank, row_above_mem[i1], raw}]};
        row_above_mem[i0] = smooth;
        row_above_mem[i1] = raw;
        prev_colour = raw;
        pens_due.push_back(p);
        pairs_sent++;
      end
      default: ignored_sent++;
    endcase
  endtask

  // driver: presents queued beats, holds each one while stalled
  beat_t beat_now;
  int    gap_left = 0;
  bit    calm_in  = 1'b0;

  always @(posedge clk_i) begin : drive_beats
    logic next_valid;
    next_valid = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_pens(beat_now);
        next_valid = 1'b0;
        gap_left = draw_wait(calm_in);
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (beats_waiting.size() > 0) begin
          beat_now = beats_waiting.pop_front();
          func_i               <= beat_now.func;
          column_i             <= beat_now.column;
          first_in_line_i      <= beat_now.line_start;
          first_in_frame_i     <= beat_now.frame_start;
          text_byte_i          <= beat_now.text;
          background_plane_a_i <= beat_now.plane_a;
          background_plane_b_i <= beat_now.plane_b;
          background_flip_i    <= beat_now.flip;
          table_index_i        <= beat_now.tindex;
          table_value_i        <= beat_now.tvalue;
          next_valid = 1'b1;
        end
      end
    end
    in_valid_i <= next_valid;
  end

  // monitor: compares each pen beat with the oldest prediction, stalls at random
  int stall_left = 0;
  bit calm_out   = 1'b0;

  always @(posedge clk_i) begin : check_pens
    pens_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pens_due.size() == 0) begin
          report($sformatf("pen beat %h/%h with no pixel pair pending",
                           pen_first_o, pen_second_o));
        end else begin
          want = pens_due.pop_front();
          if (pen_first_o !== want.first)
            report($sformatf("pen_first %h, expected %h", pen_first_o, want.first));
          if (pen_second_o !== want.second)
            report($sformatf("pen_second %h, expected %h", pen_second_o, want.second));
        end
        pens_checked++;
        stall_left = draw_wait(calm_out);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left > 0);
    end
  end

  // beat builders, every field random unless set afterwards
  function automatic beat_t rand_beat(logic [1:0] f);
    beat_t b;
    b.func        = f;
    b.column      = 9'($urandom_range(0, 511));
    b.line_start  = 1'($urandom_range(0, 1));
    b.frame_start = 1'($urandom_range(0, 1));
    b.text        = 8'($urandom_range(0, 255));
    b.plane_a     = 8'($urandom_range(0, 255));
    b.plane_b     = 8'($urandom_range(0, 255));
    b.flip        = 1'($urandom_range(0, 1));
    b.tindex      = 10'($urandom_range(0, 1023));
    b.tvalue      = 4'($urandom_range(0, 15));
    return b;
  endfunction

  function automatic beat_t pair(logic [8:0] col, logic ls, logic fs, logic flip,
                                 logic [7:0] text, logic [7:0] pa, logic [7:0] pb);
    beat_t b;
    b = rand_beat(FUNC_PIXEL);
    b.column      = col;
    b.line_start  = ls;
    b.frame_start = fs;
    b.flip        = flip;
    b.text        = text;
    b.plane_a     = pa;
    b.plane_b     = pb;
    return b;
  endfunction

  function automatic beat_t table_load(logic [1:0] f, logic [9:0] idx, logic [3:0] val);
    beat_t b;
    b = rand_beat(f);
    b.tindex = idx;
    b.tvalue = val;
    return b;
  endfunction

  // register write while the block is idle
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_HSCROLL) scroll = val;
    else bank = val[1:0];
    reg_writes++;
  endtask

  task automatic set_regs(logic [8:0] hs, logic [1:0] bk);
    write_reg(CFG_HSCROLL, hs);
    write_reg(CFG_BANK, {7'($urandom_range(0, 127)), bk});
  endtask

  // wait until every beat is taken and every pen pair has come back
  task automatic settle();
    while (beats_waiting.size() != 0 || in_valid_i || pens_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // raster lines with random content, plus noise, reloads and unused codes
  task automatic queue_random(int n);
    int    made;
    int    r;
    int    col;
    int    len;
    beat_t b;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len = ($urandom_range(0, 9) == 0) ? 256 : $urandom_range(8, 48);
        col = ($urandom_range(0, 3) == 0) ? 2 * $urandom_range(0, 255) : 0;
        for (int k = 0; k < len && col <= 510 && made < n; k++) begin
          b = rand_beat(FUNC_PIXEL);
          b.column      = 9'(col);
          b.line_start  = (k == 0);
          b.frame_start = (k == 0) && (r < 8);
          beats_waiting.push_back(b);
          made++;
          col += 2;
        end
      end else if (r < 85) begin
        beats_waiting.push_back(rand_beat(FUNC_PIXEL));
        made++;
      end else if (r < 95) begin
        beats_waiting.push_back(rand_beat(r[0] ? FUNC_LOAD_ONE : FUNC_LOAD_TWO));
        made++;
      end else begin
        beats_waiting.push_back(rand_beat(FUNC_UNUSED));
        made++;
      end
    end
  endtask

  initial begin : stimulus
    for (int k = 0; k < LINE_WIDTH; k++) row_above_mem[k] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_regs(9'd0, FILL_BANK);

    // fill the bank the pixels use in both tables before any pixel reads it
    @(negedge clk_i);
    for (int i = 0; i < 256; i++) begin
      beats_waiting.push_back(table_load(FUNC_LOAD_ONE, {FILL_BANK, 8'(i)},
                                         4'($urandom_range(0, 15))));
      beats_waiting.push_back(table_load(FUNC_LOAD_TWO, {FILL_BANK, 8'(i)},
                                         4'($urandom_range(0, 15))));
    end
    settle();

    // directed: field extremes, flip, odd columns, wrap at line end, loads, unused code
    @(negedge clk_i);
    beats_waiting.push_back(pair(9'd0,   1'b1, 1'b1, 1'b0, 8'hff, 8'h00, 8'hff));
    beats_waiting.push_back(pair(9'd2,   1'b0, 1'b0, 1'b1, 8'h00, 8'hff, 8'h00));
    beats_waiting.push_back(pair(9'd4,   1'b0, 1'b0, 1'b0, 8'he4, 8'h5a, 8'ha5));
    beats_waiting.push_back(pair(9'd6,   1'b0, 1'b0, 1'b1, 8'h1b, 8'hff, 8'hff));
    beats_waiting.push_back(pair(9'd510, 1'b0, 1'b0, 1'b0, 8'h93, 8'h00, 8'h00));
    // odd column at the line end wraps to entry zero
    beats_waiting.push_back(pair(9'd511, 1'b0, 1'b0, 1'b1, 8'h6c, 8'hc3, 8'h3c));
    // next line reads what the line above left
    beats_waiting.push_back(pair(9'd0,   1'b1, 1'b0, 1'b0, 8'hff, 8'hff, 8'hff));
    beats_waiting.push_back(pair(9'd2,   1'b0, 1'b0, 1'b1, 8'h55, 8'haa, 8'h55));
    beats_waiting.push_back(pair(9'd1,   1'b0, 1'b0, 1'b0, 8'haa, 8'h0f, 8'hf0));
    beats_waiting.push_back(table_load(FUNC_LOAD_ONE, 10'd1023, 4'hf));
    beats_waiting.push_back(table_load(FUNC_LOAD_TWO, 10'd0, 4'h0));
    beats_waiting.push_back(table_load(FUNC_LOAD_TWO, 10'd1023, 4'hf));
    beats_waiting.push_back(table_load(FUNC_LOAD_ONE, 10'd0, 4'h0));
    beats_waiting.push_back(table_load(FUNC_UNUSED, 10'd1023, 4'hf));
    // frame start clears the line store, then a pair reads it back
    beats_waiting.push_back(pair(9'd0,   1'b1, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00));
    beats_waiting.push_back(pair(9'd2,   1'b0, 1'b0, 1'b0, 8'hff, 8'hff, 8'hff));
    beats_waiting.push_back(pair(9'd0,   1'b1, 1'b0, 1'b0, 8'h81, 8'h42, 8'h24));
    beats_waiting.push_back(pair(9'd3,   1'b0, 1'b1, 1'b1, 8'h7e, 8'h18, 8'he7));
    settle();

    // random phases over several scroll settings, extremes included
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       set_regs(9'd511, FILL_BANK);
        1:       set_regs(9'd1, FILL_BANK);
        2:       set_regs(9'd0, FILL_BANK);
        default: set_regs(9'($urandom_range(0, 511)), FILL_BANK);
      endcase
      @(negedge clk_i);
      queue_random(PHASE_BEATS);
      settle();
    end

    $display("sent %0d pixel pairs, %0d table loads and %0d unused-code beats",
             pairs_sent, loads_sent, ignored_sent);
    $display("compared %0d pen pairs over %0d register writes, %0d mismatches",
             pens_checked, reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #(20 * 400000);
    $display("run timed out with %0d pen pairs outstanding", pens_due.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
